>>> src/rtuc_pkg.sv
// ----------------------------------------------------------------------------
// rtuc_pkg
// Shared types, codes and the CRC-16/MODBUS byte update for the RTU frame
// check and classify block.
// ----------------------------------------------------------------------------
package rtuc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] MIN_LEN  = 16'd7;
  localparam logic [15:0] WAVE_LEN = 16'd8;
  localparam logic [7:0]  BCAST_ADDR = 8'h00;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_ADDR = 3'd0,
    CFG_DISCOVER   = 3'd1,
    CFG_SET_ADDR   = 3'd2,
    CFG_REBOOT     = 3'd3,
    CFG_WAVE_PACK  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    VERD_ACCEPT     = 3'd0,
    VERD_DISCOVER   = 3'd1,
    VERD_SET_ADDR   = 3'd2,
    VERD_REBOOT     = 3'd3,
    VERD_SHORT      = 3'd4,
    VERD_CRC_ERR    = 3'd5,
    VERD_SHORT_WAVE = 3'd6,
    VERD_NOT_OURS   = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [7:0] local_addr;
    logic [7:0] code_discover;
    logic [7:0] code_set_addr;
    logic [7:0] code_reboot;
    logic [7:0] code_wave_pack;
  } cfg_t;

  // Frame state as it stands once the current byte is taken in
  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] rx_crc;
    logic [15:0] count;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [15:0] seq;
    logic [15:0] total;
  } trk_view_t;

  typedef struct packed {
    verdict_e    verdict;
    logic        is_bcast;
    logic [7:0]  frame_addr;
    logic [7:0]  command;
    logic [15:0] pack_seq;
    logic [15:0] pack_total;
    logic [15:0] byte_len;
  } res_t;

  // Reflected CRC-16 update with one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> src/rtuc_if.sv
// ----------------------------------------------------------------------------
// rtuc_if
// Valid/ready channels: received byte stream and frame verdict stream.
// ----------------------------------------------------------------------------
interface rtuc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface rtuc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic        is_bcast;
  logic [7:0]  frame_addr;
  logic [7:0]  command;
  logic [15:0] pack_seq;
  logic [15:0] pack_total;
  logic [15:0] byte_len;

  modport source (output valid, output verdict, output is_bcast, output frame_addr,
                  output command, output pack_seq, output pack_total,
                  output byte_len, input ready);
  modport sink   (input valid, input verdict, input is_bcast, input frame_addr,
                  input command, input pack_seq, input pack_total,
                  input byte_len, output ready);
endinterface

>>> src/rtuc_frame_track.sv
// ----------------------------------------------------------------------------
// rtuc_frame_track
// Per-frame state: running CRC, two-byte hold line, byte count and header
// captures. Cleared after the end byte of each frame.
// ----------------------------------------------------------------------------
module rtuc_frame_track
  import rtuc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output trk_view_t  view_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  held0_q, held1_q;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] total_q, total_d;

  always_comb begin
    crc_d   = (count_q >= 16'd2) ? crc_byte(crc_q, held0_q) : crc_q;
    count_d = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
    addr_d  = addr_q;
    cmd_d   = cmd_q;
    seq_d   = seq_q;
    total_d = total_q;
    case (count_q)
      16'd0:   addr_d = byte_i;
      16'd1:   cmd_d = byte_i;
      16'd2:   seq_d = {byte_i, seq_q[7:0]};
      16'd3:   seq_d = {seq_q[15:8], byte_i};
      16'd4:   total_d = {byte_i, total_q[7:0]};
      16'd5:   total_d = {total_q[15:8], byte_i};
      default: ;
    endcase
  end

  assign view_o = '{crc:    crc_d,
                    rx_crc: {byte_i, held1_q},
                    count:  count_d,
                    addr:   addr_d,
                    cmd:    cmd_d,
                    seq:    seq_d,
                    total:  total_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      count_q <= '0;
      held0_q <= '0;
      held1_q <= '0;
      addr_q  <= '0;
      cmd_q   <= '0;
      seq_q   <= '0;
      total_q <= '0;
    end else if (take_i) begin
      if (end_i) begin
        crc_q   <= CRC_INIT;
        count_q <= '0;
        held0_q <= '0;
        held1_q <= '0;
        addr_q  <= '0;
        cmd_q   <= '0;
        seq_q   <= '0;
        total_q <= '0;
      end else begin
        crc_q   <= crc_d;
        count_q <= count_d;
        held0_q <= held1_q;
        held1_q <= byte_i;
        addr_q  <= addr_d;
        cmd_q   <= cmd_d;
        seq_q   <= seq_d;
        total_q <= total_d;
      end
    end
  end

endmodule

>>> src/rtuc_classify.sv
// ----------------------------------------------------------------------------
// rtuc_classify
// Verdict decode for a finished frame, first matching test wins.
// ----------------------------------------------------------------------------
module rtuc_classify
  import rtuc_pkg::*;
(
  input  trk_view_t view_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  logic     bcast;
  logic     is_wave;
  logic     wave_ok;
  verdict_e verdict;

  assign bcast   = (view_i.addr == BCAST_ADDR);
  assign is_wave = (view_i.cmd == cfg_i.code_wave_pack);

  always_comb begin
    if (view_i.count < MIN_LEN) begin
      verdict = VERD_SHORT;
    end else if (view_i.rx_crc != view_i.crc) begin
      verdict = VERD_CRC_ERR;
    end else if (is_wave && (view_i.count < WAVE_LEN)) begin
      verdict = VERD_SHORT_WAVE;
    end else if (bcast && (view_i.cmd == cfg_i.code_discover)) begin
      verdict = VERD_DISCOVER;
    end else if (bcast && (view_i.cmd == cfg_i.code_set_addr)) begin
      verdict = VERD_SET_ADDR;
    end else if (bcast && (view_i.cmd == cfg_i.code_reboot)) begin
      verdict = VERD_REBOOT;
    end else if (!bcast && (view_i.addr != cfg_i.local_addr)) begin
      verdict = VERD_NOT_OURS;
    end else begin
      verdict = VERD_ACCEPT;
    end
  end

  // wave words pass only on frames that got past the length and CRC checks
  assign wave_ok = is_wave && (verdict != VERD_SHORT) && (verdict != VERD_CRC_ERR)
                   && (verdict != VERD_SHORT_WAVE);

  assign res_o = '{verdict:    verdict,
                   is_bcast:   bcast,
                   frame_addr: view_i.addr,
                   command:    view_i.cmd,
                   pack_seq:   wave_ok ? view_i.seq : 16'h0000,
                   pack_total: wave_ok ? view_i.total : 16'h0000,
                   byte_len:   view_i.count};

endmodule

>>> src/rtu_frame_check_classify.sv
// ----------------------------------------------------------------------------
// rtu_frame_check_classify
// Bus frame checker: CRC-16/MODBUS check and request classification.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction on rx_i, frame_end marking the last
// byte, and returns one verdict transaction on res_o per frame. A byte is taken
// every cycle; the verdict is registered as the end byte is accepted. The input
// stays ready while a verdict waits, and only stalls when the result register
// is full and its consumer is not ready in the same cycle. The longest path is
// the unrolled byte-wide CRC update followed by the 16-bit compare against the
// received CRC and the verdict priority decode. The CRC covers all bytes except
// the last two, which are read as the little-endian received CRC. Frames under
// 7 bytes are short; the wave-pack command needs exactly 8 or more. The length
// count saturates at 65535. Configuration registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while no frame
// is in flight; the block does not enforce this. Unknown indices are ignored.
// ----------------------------------------------------------------------------
module rtu_frame_check_classify
  import rtuc_pkg::*;
#(
  parameter logic [7:0] LocalAddrRst = 8'd1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rtuc_in_if.sink              rx_i,
  rtuc_out_if.source           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  cfg_t      cfg_q;
  trk_view_t view;
  res_t      res_d, res_q;
  logic      res_valid_q;
  logic      in_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_addr     <= LocalAddrRst;
      cfg_q.code_discover  <= 8'd1;
      cfg_q.code_set_addr  <= 8'd2;
      cfg_q.code_reboot    <= 8'd3;
      cfg_q.code_wave_pack <= 8'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOCAL_ADDR: cfg_q.local_addr     <= cfg_data_i;
        CFG_DISCOVER:   cfg_q.code_discover  <= cfg_data_i;
        CFG_SET_ADDR:   cfg_q.code_set_addr  <= cfg_data_i;
        CFG_REBOOT:     cfg_q.code_reboot    <= cfg_data_i;
        CFG_WAVE_PACK:  cfg_q.code_wave_pack <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Accept unless a verdict is stuck in the result register
  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign in_take    = rx_i.valid && rx_i.ready;

  rtuc_frame_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (in_take),
    .byte_i (rx_i.rx_byte),
    .end_i  (rx_i.frame_end),
    .view_o (view)
  );

  rtuc_classify u_classify (
    .view_i (view),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_take && rx_i.frame_end) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && rx_i.frame_end) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.verdict    = res_q.verdict;
  assign res_o.is_bcast   = res_q.is_bcast;
  assign res_o.frame_addr = res_q.frame_addr;
  assign res_o.command    = res_q.command;
  assign res_o.pack_seq   = res_q.pack_seq;
  assign res_o.pack_total = res_q.pack_total;
  assign res_o.byte_len   = res_q.byte_len;

  // An accepted end byte always leaves a verdict behind
  a_end_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && rx_i.frame_end) |=> res_valid_q)
    else $error("end byte accepted without a verdict");

  // A waiting verdict must block new input
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |-> !rx_i.ready)
    else $error("input ready while verdict stalled");

  // Short verdict exactly when the length is under the minimum
  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((res_q.byte_len < MIN_LEN) == (res_q.verdict == VERD_SHORT)))
    else $error("short verdict does not match frame length");

  // Short and CRC-error frames never carry wave words
  a_crc_no_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.verdict == VERD_CRC_ERR || res_q.verdict == VERD_SHORT))
      |-> (res_q.pack_seq == 16'h0000 && res_q.pack_total == 16'h0000))
    else $error("wave words on a rejected frame");

endmodule
